/* hw/rtl/mss_pkg.sv */
package mss_pkg;

  localparam int PATTERN_MAX_DEF  = 16;
  localparam int ADDRESS_BITS_DEF = 32;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 5;
  localparam int RES_ADDR_W  = 32;
  localparam int REG_ADDR_W  = 32;

  // Register file indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LO = 3'd0,
    CFG_PATTERN_HI = 3'd1,
    CFG_MASK_LO    = 3'd2,
    CFG_MASK_HI    = 3'd3,
    CFG_LENGTH     = 3'd4,
    CFG_START      = 3'd5,
    CFG_END        = 3'd6,
    CFG_WRAP_MASK  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       scan_begin;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [RES_ADDR_W-1:0] match_address;
  } res_t;

endpackage

/* hw/rtl/masked_signature_search_unit.sv */
// Masked byte-pattern search over a streamed, address-ordered byte sequence.
// A byte's result request passes the input register, then the result register.
// Throughput: 1 byte per cycle unless the consumer holds a result, set by the
//   combinational parallel window compare.
// Reset (rst, synchronous): config registers to their defaults, scan idle, both
//   pipeline slots empty; the window itself is cleared when a scan begins.
module masked_signature_search_unit #(
  parameter int PATTERN_MAX  = mss_pkg::PATTERN_MAX_DEF,
  parameter int ADDRESS_BITS = mss_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // byte stream
  input  logic                                req_valid,
  output logic                                req_stall,
  input  mss_pkg::req_t                       req,
  // results
  output logic                                res_valid,
  input  logic                                res_stall,
  output mss_pkg::res_t                       res,
  // register writes
  input  logic                                cfg_we,
  input  logic [mss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mss_pkg::*;

  localparam int SEEN_W = $clog2(PATTERN_MAX + 1);
  localparam int AW     = ADDRESS_BITS;

  // ---------------------------------------------------------------------------
  // Config registers. The wrap mask belongs to the feeder; nothing here uses it,
  // so writes to its index are dropped.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] pattern_lo, pattern_hi, mask_lo, mask_hi;
  logic [LEN_W-1:0]      pattern_length;
  logic [REG_ADDR_W-1:0] search_start, search_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_lo     <= '0;
      pattern_hi     <= '0;
      mask_lo        <= '0;
      mask_hi        <= '0;
      pattern_length <= LEN_W'(1);
      search_start   <= '0;
      search_end     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LO: pattern_lo     <= cfg_data;
        CFG_PATTERN_HI: pattern_hi     <= cfg_data;
        CFG_MASK_LO:    mask_lo        <= cfg_data;
        CFG_MASK_HI:    mask_hi        <= cfg_data;
        CFG_LENGTH:     pattern_length <= cfg_data[LEN_W-1:0];
        CFG_START:      search_start   <= cfg_data[REG_ADDR_W-1:0];
        CFG_END:        search_end     <= cfg_data[REG_ADDR_W-1:0];
        CFG_WRAP_MASK:  ;
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: one input slot (s1) feeding one result slot. s1 drains whenever
  // the result slot can be loaded, so a byte enters every cycle unless the
  // consumer holds a result.
  // ---------------------------------------------------------------------------
  logic  s1_valid;
  req_t  s1;
  logic  out_free, s1_go, req_accept;

  assign out_free   = !res_valid || !res_stall;
  assign s1_go      = s1_valid && out_free;
  assign req_stall  = s1_valid && !out_free;
  assign req_accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1 <= req;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  logic [PATTERN_MAX-1:0][7:0] window, window_base, window_next;
  logic [AW-1:0]               next_address;
  logic [SEEN_W-1:0]           bytes_seen;
  logic                        scan_finished;

  logic [AW-1:0]     start_aligned, hi, cur_addr, match_start;
  logic [SEEN_W-1:0] cur_seen, seen_next, eff_len;
  logic              cur_finished, in_range, is_last, cand, hit;
  logic              emit;
  res_t              res_next;

  // Pattern and mask byte lanes, byte 0 in the low lane.
  logic [2*CFG_DATA_W-1:0]     pattern_all, mask_all;
  logic [PATTERN_MAX-1:0][7:0] pattern_lanes, mask_lanes;

  // Start is halfword aligned; both bounds cut to the address width.
  assign start_aligned = {search_start[AW-1:1], 1'b0};
  assign hi            = search_end[AW-1:0];

  // Zero length acts as one, anything past the window size as the window size.
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = SEEN_W'(1);
    end else if (pattern_length > LEN_W'(PATTERN_MAX)) begin
      eff_len = SEEN_W'(PATTERN_MAX);
    end else begin
      eff_len = SEEN_W'(pattern_length);
    end
  end

  // A begin byte restarts the scan in the same cycle it is processed.
  assign cur_finished = s1.scan_begin ? 1'b0 : scan_finished;
  assign cur_addr     = s1.scan_begin ? start_aligned : next_address;
  assign cur_seen     = s1.scan_begin ? '0 : bytes_seen;
  assign window_base  = s1.scan_begin ? '0 : window;
  assign seen_next    = (cur_seen == SEEN_W'(PATTERN_MAX)) ? cur_seen
                                                           : cur_seen + SEEN_W'(1);

  always_comb begin
    window_next = window_base;
    for (int k = PATTERN_MAX - 1; k > 0; k--) begin
      window_next[k] = window_base[k-1];
    end
    window_next[0] = s1.data_byte;
  end

  // Window ending at cur_addr starts at cur_addr - (len - 1).
  assign match_start = cur_addr - AW'(eff_len - SEEN_W'(1));
  assign in_range    = cur_addr < hi;
  assign is_last     = ({1'b0, cur_addr} + (AW+1)'(1)) >= {1'b0, hi};
  assign cand        = in_range && (seen_next >= eff_len) && !match_start[0];

  assign pattern_all   = {pattern_hi, pattern_lo};
  assign mask_all      = {mask_hi, mask_lo};
  assign pattern_lanes = pattern_all[PATTERN_MAX*8-1:0];
  assign mask_lanes    = mask_all[PATTERN_MAX*8-1:0];

  mss_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .SEEN_W      (SEEN_W)
  ) u_match (
    .window  (window_next),
    .pattern (pattern_lanes),
    .mask    (mask_lanes),
    .len     (eff_len),
    .hit     (hit)
  );

  // A match wins over the end of range; either closes the scan.
  always_comb begin
    emit                   = 1'b0;
    res_next.found         = 1'b0;
    res_next.match_address = '0;
    if (!cur_finished) begin
      if (cand && hit) begin
        emit                   = 1'b1;
        res_next.found         = 1'b1;
        res_next.match_address = RES_ADDR_W'(match_start);
      end else if (is_last) begin
        emit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_finished <= 1'b1;
      bytes_seen    <= '0;
      next_address  <= '0;
    end else if (s1_go && !cur_finished) begin
      scan_finished <= emit;
      bytes_seen    <= seen_next;
      next_address  <= cur_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !cur_finished) begin
      window <= window_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res <= res_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_found_aligned: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.found |-> !res.match_address[0])
    else $error("match reported at an odd address");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.found |-> res.match_address == '0)
    else $error("not-found request carries a nonzero address");

  a_close_scan: assert property (@(posedge clk) disable iff (rst)
    s1_go && emit |=> scan_finished && res_valid)
    else $error("result issued without closing the scan");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && res_valid && res_stall)
    else $error("input stalled without a held result");

endmodule

/* hw/rtl/mss_match.sv */
module mss_match #(
  parameter int PATTERN_MAX = mss_pkg::PATTERN_MAX_DEF,
  parameter int SEEN_W      = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX-1:0][7:0] window,
  input  logic [PATTERN_MAX-1:0][7:0] pattern,
  input  logic [PATTERN_MAX-1:0][7:0] mask,
  input  logic [SEEN_W-1:0]           len,
  output logic                        hit
);
  import mss_pkg::*;

  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [PATTERN_MAX-1:0] lane_ok;

  // Pattern byte i lines up with the window entry len-1-i (entry 0 is newest).
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_lane
    logic [SEEN_W-1:0] tap;
    assign tap        = len - SEEN_W'(i + 1);
    assign lane_ok[i] = (SEEN_W'(i) >= len) ||
                        (((window[tap[IW-1:0]] ^ pattern[i]) & mask[i]) == 8'd0);
  end

  assign hit = &lane_ok;

endmodule

/* test/tb_masked_signature_search_unit.sv */
module tb_masked_signature_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  // Two register stages between a byte and its result.
  localparam int PIPE_DEPTH  = 2;
  // Quiet cycles (nothing accepted on either side) before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_BYTES = 1700;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  masked_signature_search_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file and of the scan state
  // ---------------------------------------------------------------------------
  logic [63:0]      pat_lo = '0, pat_hi = '0, msk_lo = '0, msk_hi = '0;
  logic [LEN_W-1:0] len_reg = 5'd1;
  logic [31:0]      start_reg = '0, end_reg = '0, wrap_reg = '1;

  logic [7:0]       win [16];      // entry 0 is the newest byte
  logic [31:0]      next_addr = '0;
  logic [4:0]       seen = '0;     // saturates at PATTERN_MAX
  logic             scan_idle = 1'b1;

  res_t expected_results [$];

  bit          steady = 1'b0;      // when set, neither side inserts bubbles
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned scans_run = 0;
  int unsigned settings_used = 0;
  int unsigned hits_seen = 0;
  int unsigned misses_seen = 0;
  int unsigned quiet_cycles = 0;

  // Effective compare length: 0 acts as 1, anything past the window acts as full width.
  function automatic int unsigned eff_len(input logic [LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
    return l;
  endfunction

  // Advance the shadow scan by one byte. Returns 1 when that byte produces a result.
  function automatic bit search_step(input logic [7:0] d, input logic first, output res_t r);
    int unsigned  n;
    logic [32:0]  end_x;
    logic [31:0]  pos;
    logic [31:0]  at;
    logic [127:0] pat;
    logic [127:0] msk;
    logic [7:0]   m;
    bit           hit;
    r   = '0;
    pat = {pat_hi, pat_lo};
    msk = {msk_hi, msk_lo};
    // scan_begin always restarts, even in the middle of a scan
    if (first) begin
      for (int i = 0; i < 16; i++) win[i] = '0;
      next_addr = start_reg & ~32'd1;
      seen      = '0;
      scan_idle = 1'b0;
    end
    if (scan_idle) return 1'b0;
    for (int i = 15; i > 0; i--) win[i] = win[i-1];
    win[0] = d;
    if (seen < PATTERN_MAX_DEF) seen++;
    pos   = next_addr;
    n     = eff_len(len_reg);
    end_x = {1'b0, pos} + 33'd1;
    // candidate window must end below search_end, be full, and start on an even address
    if (end_x <= {1'b0, end_reg} && seen >= n) begin
      at = pos - (n - 1);
      if (!at[0]) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
          m = msk[8*i +: 8];
          if ((win[n-1-i] & m) != (pat[8*i +: 8] & m)) hit = 1'b0;
        end
        if (hit) begin
          scan_idle       = 1'b1;
          r.found         = 1'b1;
          r.match_address = at;
          return 1'b1;
        end
      end
    end
    // last address that can close a window: report not-found
    if (end_x >= {1'b0, end_reg}) begin
      scan_idle = 1'b1;
      return 1'b1;
    end
    next_addr = pos + 32'd1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: acceptance on the request side feeds the shadow scan; accepted
  // results are compared against the oldest expectation. Sampled at posedge,
  // before the DUT's nonblocking updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t r;
    if (!rst && req_valid && !req_stall) begin
      if (search_step(req.data_byte, req.scan_begin, r)) expected_results.push_back(r);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $error("unexpected result: found=%0d match_address=%h", res.found, res.match_address);
      end else begin
        want = expected_results.pop_front();
        if (res.found !== want.found) begin
          errors++;
          $error("found: expected %0d, got %0d", want.found, res.found);
        end
        if (res.match_address !== want.match_address) begin
          errors++;
          $error("match_address: expected %h, got %h", want.match_address, res.match_address);
        end
        if (want.found) hits_seen++;
        else misses_seen++;
      end
    end
  end

  // Result-side back-pressure, about 16% of cycles unless in a steady stretch.
  always @(negedge clk) res_stall <= !steady && ($urandom_range(99) < 16);

  // Hang detector.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d results still outstanding", expected_results.size());
        $display("tb_masked_signature_search_unit failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Push one byte request; random bubbles before it, payload held while stalled.
  task automatic send_byte(input logic [7:0] d, input logic first);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 16) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{data_byte: d, scan_begin: first};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Hold off the sender until every expected result is back. With settle set,
  // also give trailing no-result bytes time to leave the pipe.
  task automatic wait_drain(input bit settle);
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    if (settle) repeat (PIPE_DEPTH + 3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      CFG_PATTERN_LO: pat_lo    = v;
      CFG_PATTERN_HI: pat_hi    = v;
      CFG_MASK_LO:    msk_lo    = v;
      CFG_MASK_HI:    msk_hi    = v;
      CFG_LENGTH:     len_reg   = v[LEN_W-1:0];
      CFG_START:      start_reg = v[31:0];
      CFG_END:        end_reg   = v[31:0];
      CFG_WRAP_MASK:  wrap_reg  = v[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Rewrite the whole register file once the block has gone quiet.
  task automatic program_regs(input logic [63:0] pl, input logic [63:0] ph,
                              input logic [63:0] ml, input logic [63:0] mh,
                              input logic [63:0] len, input logic [63:0] st,
                              input logic [63:0] en, input logic [63:0] wr);
    wait_drain(1'b1);
    write_reg(CFG_PATTERN_LO, pl);
    write_reg(CFG_PATTERN_HI, ph);
    write_reg(CFG_MASK_LO, ml);
    write_reg(CFG_MASK_HI, mh);
    write_reg(CFG_LENGTH, len);
    write_reg(CFG_START, st);
    write_reg(CFG_END, en);
    write_reg(CFG_WRAP_MASK, wr);
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: a stray byte is ignored while idle; with search_end still 0
  // the first scan byte reports not-found right away.
  task automatic check_reset_defaults();
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    scans_run++;
    wait_drain(1'b1);
  endtask

  task automatic check_directed_cases();
    // two-byte pattern 00 FF at address zero; data extremes
    program_regs(64'hFF00, 64'h0, 64'hFFFF, 64'h0, 64'd2, 64'd0, 64'd8, 64'hFFFF_FFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    // restart mid-scan: first attempt mismatches, restart then hits at zero
    send_byte(8'h00, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    scans_run += 3;

    // odd start gets aligned down; a hit at an odd address is skipped
    program_regs(64'hFF, 64'h0, 64'hFF, 64'h0, 64'd1, 64'd3, 64'd6, 64'h0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    scans_run++;

    // range shorter than the pattern: not-found at search_end - 1
    program_regs(64'h0123_4567_89AB_CDEF, 64'h0, '1, '1, 64'd4, 64'd2, 64'd4, 64'h0000_FFFF);
    send_byte(8'hEF, 1'b1);
    send_byte(8'hCD, 1'b0);
    scans_run++;

    // length 0 acts as 1, all-wildcard mask, topmost even address
    program_regs('1, '1, 64'h0, 64'h0, 64'd0, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hAAAA_5555);
    send_byte(8'h3C, 1'b1);
    scans_run++;

    // empty range at a nonzero start
    program_regs(64'h0, 64'h0, '1, '1, 64'd16, 64'h8000_0000, 64'h7FFF_FFFF, '1);
    send_byte(8'hC3, 1'b1);
    scans_run++;
    wait_drain(1'b1);
  endtask

  // Random register settings, each followed by a handful of well-formed scans
  // (often with a planted match), plus stray bytes and cut-short scans.
  task automatic check_random_scans();
    logic [127:0]     pat;
    logic [127:0]     msk;
    logic [LEN_W-1:0] lenv;
    logic [63:0]      lenw;
    logic [31:0]      s;
    logic [31:0]      e;
    logic [31:0]      base;
    logic [32:0]      e33;
    logic [7:0]       d;
    logic [7:0]       m;
    int unsigned      phase;
    int unsigned      span;
    int unsigned      n;
    int unsigned      off;
    int unsigned      stop;
    bit               planted;
    bit               cut;
    phase = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      steady = (phase >= 12 && phase < 20);

      pat = {$urandom, $urandom, $urandom, $urandom};
      for (int i = 0; i < 16; i++) begin
        case ($urandom_range(3))
          0:       msk[8*i +: 8] = 8'h00;
          3:       msk[8*i +: 8] = 8'($urandom_range(255));
          default: msk[8*i +: 8] = 8'hFF;
        endcase
      end
      case ($urandom_range(9))
        0:       lenv = 5'd0;
        1:       lenv = LEN_W'($urandom_range(17, 31));
        2:       lenv = 5'd16;
        3:       lenv = 5'd1;
        default: lenv = LEN_W'($urandom_range(2, 15));
      endcase
      case ($urandom_range(9))
        0:       s = 32'h0;
        1:       s = 32'hFFFF_FFC0 | $urandom_range(63);
        2:       s = 32'hFFFF_FFFF;
        default: s = $urandom;
      endcase
      base = s & ~32'd1;
      if ($urandom_range(99) < 8) begin
        e = (base > 4) ? base - $urandom_range(4) : base;
      end else begin
        e33 = {1'b0, base} + $urandom_range(1, 48);
        e   = e33[32] ? 32'hFFFF_FFFF : e33[31:0];
      end
      // narrow registers get junk in the unused upper bits
      lenw = {$urandom, $urandom};
      lenw[LEN_W-1:0] = lenv;
      program_regs(pat[63:0], pat[127:64], msk[63:0], msk[127:64], lenw,
                   {$urandom, s}, {$urandom, e}, {$urandom, $urandom});

      repeat ($urandom_range(3, 8)) begin
        // stray bytes: ignored when idle, continue a cut-short scan otherwise
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
        end
        span    = (e > base) ? e - base : 1;
        n       = eff_len(lenv);
        planted = (span >= n) && ($urandom_range(99) < 70);
        off     = planted ? 2 * $urandom_range((span - n) / 2) : 0;
        stop    = planted ? off + n + $urandom_range(2) : span;
        cut     = $urandom_range(99) < 12;
        if (cut) stop = $urandom_range(1, stop);
        for (int k = 0; k < stop; k++) begin
          d = 8'($urandom_range(255));
          if (planted && k >= off && k < off + n) begin
            m = msk[8*(k-off) +: 8];
            d = (pat[8*(k-off) +: 8] & m) | (d & ~m);
          end
          send_byte(d, k == 0);
          bytes_sent++;
        end
        scans_run++;
        // sometimes let the result side catch up completely before going on
        if ($urandom_range(99) < 15) wait_drain(1'b0);
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 16; i++) win[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reset_defaults();
    check_directed_cases();
    check_random_scans();
    wait_drain(1'b1);

    $display("covered %0d scans (%0d random bytes) over %0d register settings",
             scans_run, bytes_sent, settings_used);
    $display("checked %0d match results and %0d not-found results", hits_seen, misses_seen);
    if (errors == 0) begin
      $display("tb_masked_signature_search_unit passed");
    end else begin
      $display("tb_masked_signature_search_unit failed");
    end
    $finish;
  end

endmodule
